// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASCP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ASCP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/ascp_pkg.sv =====
`default_nettype none

package ascp_pkg;

   // parser states; the unused code is handled as idle
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_ESC  = 2'd1,
      ST_SEQ  = 2'd2
   } parse_state_type;

   // result actions
   typedef enum logic [1:0] {
      ACT_PRINT = 2'd0,
      ACT_FG    = 2'd1,
      ACT_BG    = 2'd2,
      ACT_DEF   = 2'd3
   } action_type;

   // configuration register indexes
   typedef enum logic {
      CSR_DEFAULT_FG = 1'b0,
      CSR_DEFAULT_BG = 1'b1
   } csr_index_type;

   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_OPEN = 8'h5B;
   localparam logic [7:0] CH_SEP  = 8'h3B;
   localparam logic [7:0] CH_END  = 8'h6D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam logic [7:0] CODE_RESET = 8'd0;
   localparam logic [7:0] CODE_FG_LO = 8'd30;
   localparam logic [7:0] CODE_FG_HI = 8'd37;
   localparam logic [7:0] CODE_BG_LO = 8'd40;
   localparam logic [7:0] CODE_BG_HI = 8'd47;
   localparam logic [7:0] ACCUM_MAX  = 8'd255;

   localparam logic [3:0] DEFAULT_FG_RESET = 4'd7;
   localparam logic [3:0] DEFAULT_BG_RESET = 4'd0;

   // sgr color digit to vga palette index
   function automatic logic [3:0] vga_palette(input logic [2:0] digit);
      logic [3:0] idx;
      case (digit)
         3'd0:    idx = 4'd0;
         3'd1:    idx = 4'd12;
         3'd2:    idx = 4'd10;
         3'd3:    idx = 4'd14;
         3'd4:    idx = 4'd9;
         3'd5:    idx = 4'd13;
         3'd6:    idx = 4'd11;
         default: idx = 4'd15;
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== src/ascp_if.sv =====
`default_nettype none

// request channel: one text byte
interface ascp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_string;

   modport source (output valid, output char_in, output end_of_string, input ready);
   modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface

// result channel: one print or color action
interface ascp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] char_out;
   logic [3:0] fg_color;
   logic [3:0] bg_index;

   modport source (output valid, output action, output char_out, output fg_color,
                   output bg_index, input ready);
   modport sink   (input valid, input action, input char_out, input fg_color,
                   input bg_index, output ready);
endinterface

`default_nettype wire

// ===== src/ansi_sgr_color_parser_unit.sv =====
// ansi sgr color parser
//
// req_if carries one text byte per request plus an end-of-string flag. rsp_if
// carries at most one result per request: a byte to print, a foreground or
// background color, or both default colors. csr_we/csr_index/csr_wdata write
// the default foreground (index 0) and background (index 1); write them only
// while the parser is idle.
//
// a request is taken into an input register, decoded against the parse state
// and its result lands in the output register, so a result passes through both
// registers before it is valid on rsp_if. one request is taken every cycle while
// the output register can take a new result; the next state and accumulator are
// computed from the held request and registered.
//
// reset (synchronous, active high) returns the parser to idle, clears the
// code accumulator, empties both registers and restores the defaults to
// foreground 7 and background 0. when the receiver holds rsp_if.ready low the
// output register holds its result, the input register fills behind it and
// then req_if.ready drops until the result is taken.
`default_nettype none

module ansi_sgr_color_parser_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   ascp_req_if.sink        req_if,
   ascp_rsp_if.source      rsp_if,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [3:0] csr_wdata
);

   // configuration registers
   logic [3:0] default_fg_ff;
   logic [3:0] default_bg_ff;

   // input register
   logic       s1_valid_ff;
   logic [7:0] s1_char_ff;
   logic       s1_eos_ff;

   // parser state
   ascp_pkg::parse_state_type state_ff, state_in;
   logic [7:0] accum_ff, accum_in;

   // output register
   logic       rsp_valid_ff;
   logic [1:0] rsp_action_ff;
   logic [7:0] rsp_char_ff;
   logic [3:0] rsp_fg_ff;
   logic [3:0] rsp_bg_ff;

   // decode results
   logic       out_free;
   logic       s2_fire;
   logic       res_valid;
   ascp_pkg::action_type res_action;
   logic [7:0] res_char;
   logic [3:0] res_fg;
   logic [3:0] res_bg;

   logic        is_digit;
   logic        is_apply;
   logic [11:0] accum_next_wide;
   logic [7:0]  fg_offset;
   logic [7:0]  bg_offset;

   // output register can take a new result
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   // decode stage consumes the held request
   assign s2_fire  = s1_valid_ff && out_free;

   assign req_if.ready = !s1_valid_ff || out_free;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         default_fg_ff <= ascp_pkg::DEFAULT_FG_RESET;
         default_bg_ff <= ascp_pkg::DEFAULT_BG_RESET;
      end else if (csr_we) begin
         unique case (ascp_pkg::csr_index_type'(csr_index))
            ascp_pkg::CSR_DEFAULT_FG: default_fg_ff <= csr_wdata;
            ascp_pkg::CSR_DEFAULT_BG: default_bg_ff <= csr_wdata;
            default:                  default_fg_ff <= default_fg_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_char_ff <= req_if.char_in;
         s1_eos_ff  <= req_if.end_of_string;
      end
   end

   // byte classes and the decimal accumulate (acc * 10 + digit)
   assign is_digit = (s1_char_ff >= ascp_pkg::CH_ZERO) && (s1_char_ff <= ascp_pkg::CH_NINE);
   assign is_apply = (s1_char_ff == ascp_pkg::CH_SEP) || (s1_char_ff == ascp_pkg::CH_END);
   assign accum_next_wide = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                          + {8'd0, s1_char_ff[3:0]};

   // palette offsets from the start of each code range
   assign fg_offset = accum_ff - ascp_pkg::CODE_FG_LO;
   assign bg_offset = accum_ff - ascp_pkg::CODE_BG_LO;

   // next state and accumulator
   always_comb begin
      state_in = state_ff;
      accum_in = accum_ff;
      if (s2_fire) begin
         unique case (state_ff)
            ascp_pkg::ST_ESC: begin
               if (s1_char_ff == ascp_pkg::CH_OPEN) begin
                  state_in = ascp_pkg::ST_SEQ;
                  accum_in = '0;
               end else begin
                  state_in = ascp_pkg::ST_IDLE;
               end
            end
            ascp_pkg::ST_SEQ: begin
               if (is_digit) begin
                  // saturate at 255
                  accum_in = (accum_next_wide > {4'd0, ascp_pkg::ACCUM_MAX})
                           ? ascp_pkg::ACCUM_MAX : accum_next_wide[7:0];
               end else if (is_apply) begin
                  accum_in = '0;
                  if (s1_char_ff == ascp_pkg::CH_END) begin
                     state_in = ascp_pkg::ST_IDLE;
                  end
               end
            end
            default: begin
               // idle, and the unused code treated as idle
               state_in = (s1_char_ff == ascp_pkg::CH_ESC) ? ascp_pkg::ST_ESC
                                                          : ascp_pkg::ST_IDLE;
            end
         endcase
         if (s1_eos_ff) begin
            state_in = ascp_pkg::ST_IDLE;
            accum_in = '0;
         end
      end
   end

   // result decode
   always_comb begin
      res_valid  = 1'b0;
      res_action = ascp_pkg::ACT_PRINT;
      res_char   = '0;
      res_fg     = '0;
      res_bg     = '0;
      unique case (state_ff)
         ascp_pkg::ST_ESC: begin
            // anything but '[' after esc is printed
            if (s1_char_ff != ascp_pkg::CH_OPEN) begin
               res_valid = 1'b1;
               res_char  = s1_char_ff;
            end
         end
         ascp_pkg::ST_SEQ: begin
            if (is_apply) begin
               if (accum_ff == ascp_pkg::CODE_RESET) begin
                  res_valid  = 1'b1;
                  res_action = ascp_pkg::ACT_DEF;
                  res_fg     = default_fg_ff;
                  res_bg     = default_bg_ff;
               end else if (accum_ff >= ascp_pkg::CODE_FG_LO
                            && accum_ff <= ascp_pkg::CODE_FG_HI) begin
                  res_valid  = 1'b1;
                  res_action = ascp_pkg::ACT_FG;
                  res_fg     = ascp_pkg::vga_palette(fg_offset[2:0]);
               end else if (accum_ff >= ascp_pkg::CODE_BG_LO
                            && accum_ff <= ascp_pkg::CODE_BG_HI) begin
                  res_valid  = 1'b1;
                  res_action = ascp_pkg::ACT_BG;
                  res_bg     = ascp_pkg::vga_palette(bg_offset[2:0]);
               end
               // other codes are dropped
            end
         end
         default: begin
            if (s1_char_ff != ascp_pkg::CH_ESC) begin
               res_valid = 1'b1;
               res_char  = s1_char_ff;
            end
         end
      endcase
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ascp_pkg::ST_IDLE;
         accum_ff <= '0;
      end else begin
         state_ff <= state_in;
         accum_ff <= accum_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_fire && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire && res_valid) begin
         rsp_action_ff <= res_action;
         rsp_char_ff   <= res_char;
         rsp_fg_ff     <= res_fg;
         rsp_bg_ff     <= res_bg;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.action   = rsp_action_ff;
   assign rsp_if.char_out = rsp_char_ff;
   assign rsp_if.fg_color = rsp_fg_ff;
   assign rsp_if.bg_index = rsp_bg_ff;

endmodule

`default_nettype wire

// ===== src/ascp_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module ascp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_action,
   input wire logic [7:0] rsp_char_out,
   input wire logic [3:0] rsp_fg_color,
   input wire logic [3:0] rsp_bg_index
);

   // print results carry no colors
   property p_print_no_color;
      rsp_valid && rsp_action == ascp_pkg::ACT_PRINT
         |-> rsp_fg_color == 4'd0 && rsp_bg_index == 4'd0;
   endproperty

   // color results carry no byte, and a single color leaves the other one zero
   property p_color_fields;
      rsp_valid && rsp_action != ascp_pkg::ACT_PRINT
         |-> rsp_char_out == 8'd0
             && (rsp_action != ascp_pkg::ACT_FG || rsp_bg_index == 4'd0)
             && (rsp_action != ascp_pkg::ACT_BG || rsp_fg_color == 4'd0);
   endproperty

   // a stalled result stays offered
   `ASCP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   `ASCP_ASSERT(a_print_no_color, p_print_no_color, "print result with color bits")

   `ASCP_ASSERT(a_color_fields, p_color_fields, "color result with stray fields")

   // reset empties the output register
   `ASCP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind ansi_sgr_color_parser_unit ascp_checker u_ascp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_action   (rsp_if.action),
   .rsp_char_out (rsp_if.char_out),
   .rsp_fg_color (rsp_if.fg_color),
   .rsp_bg_index (rsp_if.bg_index)
);

`default_nettype wire

// ===== verif/ansi_sgr_color_parser_unit_test.sv =====
`timescale 1ns / 1ps

module ansi_sgr_color_parser_unit_test;

   // one result as it shows on the result channel
   typedef struct {
      ascp_pkg::action_type action;
      logic [7:0]           char_out;
      logic [3:0]           fg_color;
      logic [3:0]           bg_index;
   } color_result_type;

   // one line of the directed stimulus; pinned lines carry a hand-written result
   typedef struct {
      logic [7:0]       ch;
      bit               last;
      bit               pinned;
      bit               fires;
      color_result_type res;
   } stim_row_type;

   localparam color_result_type NO_RESULT = '{ascp_pkg::ACT_PRINT, 8'd0, 4'd0, 4'd0};
   // sgr color digit 7..0 to vga index, four bits per digit
   localparam logic [31:0] VGA_INDEX = {4'd15, 4'd11, 4'd13, 4'd9,
                                        4'd14, 4'd10, 4'd12, 4'd0};
   localparam int SETTLE_CYCLES = 6;   // two-stage pipe plus margin
   localparam int PHASE_ITEMS   = 375;

   logic clock = 1'b0;
   logic reset;
   logic       csr_we;
   logic       csr_index;
   logic [3:0] csr_wdata;

   ascp_req_if req_chan ();
   ascp_rsp_if rsp_chan ();

   ansi_sgr_color_parser_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // idling knobs, changed per phase
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // shadow of the parser: state, accumulator and default colors
   ascp_pkg::parse_state_type sgr_state = ascp_pkg::ST_IDLE;
   logic [7:0]                sgr_code  = '0;
   logic [3:0]                dflt_fg   = ascp_pkg::DEFAULT_FG_RESET;
   logic [3:0]                dflt_bg   = ascp_pkg::DEFAULT_BG_RESET;

   color_result_type pending_results[$];
   stim_row_type     directed_rows[$];
   int               mismatch_count = 0;
   int               stim_count     = 0;

   // hand-written result that travels with the request, for pinned rows
   bit               pin_on    = 1'b0;
   bit               pin_fires = 1'b0;
   color_result_type pin_res   = NO_RESULT;

   // walk one byte through the shadow parser; fires is set when a result comes out
   function automatic void predict_request(input logic [7:0] ch, input logic last,
                                           output bit fires, output color_result_type res);
      logic [11:0] acc_next;
      logic [7:0]  off;
      fires = 1'b0;
      res   = NO_RESULT;
      case (sgr_state)
         ascp_pkg::ST_ESC: begin
            if (ch == ascp_pkg::CH_OPEN) begin
               sgr_state = ascp_pkg::ST_SEQ;
               sgr_code  = '0;
            end else begin
               // anything but the opening bracket is printed, another esc too
               fires        = 1'b1;
               res.char_out = ch;
               sgr_state    = ascp_pkg::ST_IDLE;
            end
         end
         ascp_pkg::ST_SEQ: begin
            if (ch >= ascp_pkg::CH_ZERO && ch <= ascp_pkg::CH_NINE) begin
               acc_next = sgr_code * 4'd10 + (ch - ascp_pkg::CH_ZERO);
               sgr_code = (acc_next > ascp_pkg::ACCUM_MAX) ? ascp_pkg::ACCUM_MAX
                                                           : acc_next[7:0];
            end else if (ch == ascp_pkg::CH_SEP || ch == ascp_pkg::CH_END) begin
               if (sgr_code == ascp_pkg::CODE_RESET) begin
                  fires        = 1'b1;
                  res.action   = ascp_pkg::ACT_DEF;
                  res.fg_color = dflt_fg;
                  res.bg_index = dflt_bg;
               end else if (sgr_code >= ascp_pkg::CODE_FG_LO
                            && sgr_code <= ascp_pkg::CODE_FG_HI) begin
                  off          = sgr_code - ascp_pkg::CODE_FG_LO;
                  fires        = 1'b1;
                  res.action   = ascp_pkg::ACT_FG;
                  res.fg_color = VGA_INDEX[off[2:0] * 4 +: 4];
               end else if (sgr_code >= ascp_pkg::CODE_BG_LO
                            && sgr_code <= ascp_pkg::CODE_BG_HI) begin
                  off          = sgr_code - ascp_pkg::CODE_BG_LO;
                  fires        = 1'b1;
                  res.action   = ascp_pkg::ACT_BG;
                  res.bg_index = VGA_INDEX[off[2:0] * 4 +: 4];
               end
               sgr_code = '0;
               if (ch == ascp_pkg::CH_END) sgr_state = ascp_pkg::ST_IDLE;
            end
            // any other byte inside a sequence is dropped, accumulator kept
         end
         default: begin
            if (ch == ascp_pkg::CH_ESC) begin
               sgr_state = ascp_pkg::ST_ESC;
            end else begin
               fires        = 1'b1;
               res.char_out = ch;
               sgr_state    = ascp_pkg::ST_IDLE;
            end
         end
      endcase
      // end of string always drops the parser back to idle
      if (last) begin
         sgr_state = ascp_pkg::ST_IDLE;
         sgr_code  = '0;
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // all sampling at the rising edge, before the edge's updates land
   always @(posedge clock) begin : watch_block
      bit               fires;
      color_result_type res;
      color_result_type want;
      if (reset) begin
         sgr_state = ascp_pkg::ST_IDLE;
         sgr_code  = '0;
         dflt_fg   = ascp_pkg::DEFAULT_FG_RESET;
         dflt_bg   = ascp_pkg::DEFAULT_BG_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ascp_pkg::CSR_DEFAULT_FG: dflt_fg = csr_wdata;
               ascp_pkg::CSR_DEFAULT_BG: dflt_bg = csr_wdata;
            endcase
         end
         // accepted result: compare with the oldest pending one
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %0d/%0d/%0d/%0d",
                        $time, rsp_chan.action, rsp_chan.char_out, rsp_chan.fg_color,
                        rsp_chan.bg_index);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("action", want.action, rsp_chan.action);
               check_field("char_out", want.char_out, rsp_chan.char_out);
               check_field("fg_color", want.fg_color, rsp_chan.fg_color);
               check_field("bg_index", want.bg_index, rsp_chan.bg_index);
            end
         end
         // accepted request: advance the shadow and queue what it should give
         if (req_chan.valid && req_chan.ready) begin
            predict_request(req_chan.char_in, req_chan.end_of_string, fires, res);
            if (pin_on) begin
               fires = pin_fires;
               res   = pin_res;
            end
            if (fires) pending_results.push_back(res);
         end
      end
   end

   // receiver: random back-pressure at the phase's stall rate
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // hand one request over; valid stays high between back-to-back requests
   task automatic send_byte(input logic [7:0] ch, input bit last, input bit pinned,
                            input bit fires, input color_result_type res);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.char_in       <= ch;
      req_chan.end_of_string <= last;
      pin_on                 <= pinned;
      pin_fires              <= fires;
      pin_res                <= res;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // random request with an occasional end of string; filler bytes do not count
   task automatic send_random(input logic [7:0] ch, input bit counted);
      send_byte(ch, ($urandom_range(39) == 0), 1'b0, 1'b0, NO_RESULT);
      if (counted) stim_count++;
   endtask

   // decimal digits of a code, as a terminal would send them
   task automatic send_number(input int unsigned value);
      string digits;
      digits = $sformatf("%0d", value);
      for (int i = 0; i < digits.len(); i++) send_random(digits[i], 1'b1);
   endtask

   // stop sending and let every pending result come out, plus pipe settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_defaults(input logic [3:0] fg, input logic [3:0] bg);
      csr_we    <= 1'b1;
      csr_index <= ascp_pkg::CSR_DEFAULT_FG;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= ascp_pkg::CSR_DEFAULT_BG;
      csr_wdata <= bg;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic void add_row(input logic [7:0] ch, input bit last, input bit pinned,
                                   input bit fires, input ascp_pkg::action_type act,
                                   input logic [7:0] chr, input logic [3:0] fg,
                                   input logic [3:0] bg);
      stim_row_type row;
      row.ch     = ch;
      row.last   = last;
      row.pinned = pinned;
      row.fires  = fires;
      row.res    = '{act, chr, fg, bg};
      directed_rows.push_back(row);
   endfunction

   // one random burst: mostly well-formed sgr sequences, the rest noise
   task automatic random_burst();
      int kind;
      int n_params;
      int style;
      kind = $urandom_range(9);
      if (kind <= 5) begin
         send_random(ascp_pkg::CH_ESC, 1'b1);
         send_random(ascp_pkg::CH_OPEN, 1'b1);
         n_params = $urandom_range(1, 4);
         for (int p = 0; p < n_params; p++) begin
            style = $urandom_range(9);
            case (style)
               0:       ;                                         // empty code acts as reset
               1:       send_number(ascp_pkg::CODE_RESET);
               2, 3, 4: send_number(ascp_pkg::CODE_FG_LO + $urandom_range(7));
               5, 6, 7: send_number(ascp_pkg::CODE_BG_LO + $urandom_range(7));
               8:       send_number($urandom_range(255));
               default: send_number($urandom_range(256, 999999)); // saturating code
            endcase
            // stray letter inside the sequence, dropped by the parser
            if ($urandom_range(15) == 0) send_random(8'($urandom_range(8'h41, 8'h5A)), 1'b0);
            send_random((p == n_params - 1) ? ascp_pkg::CH_END : ascp_pkg::CH_SEP, 1'b1);
         end
      end else if (kind <= 7) begin
         // plain text, any byte value
         repeat ($urandom_range(1, 8)) send_random(8'($urandom_range(255)), 1'b1);
      end else if (kind == 8) begin
         // esc followed by a random byte, usually not the bracket
         send_random(ascp_pkg::CH_ESC, 1'b1);
         send_random(8'($urandom_range(255)), 1'b1);
      end else begin
         // sequence cut short; whatever follows lands inside it
         send_random(ascp_pkg::CH_ESC, 1'b1);
         send_random(ascp_pkg::CH_OPEN, 1'b1);
         send_number($urandom_range(99));
      end
   endtask

   // stimulus
   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.char_in       <= '0;
      req_chan.end_of_string <= 1'b0;
      csr_we                 <= 1'b0;
      csr_index              <= ascp_pkg::CSR_DEFAULT_FG;
      csr_wdata              <= '0;

      // directed table, defaults still at reset values (fg 7, bg 0)
      add_row(8'h41, 0, 1, 1, ascp_pkg::ACT_PRINT, 8'h41, 4'd0, 4'd0);   // plain letter
      add_row(8'h00, 0, 1, 1, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);   // zero byte prints
      add_row(8'hFF, 0, 1, 1, ascp_pkg::ACT_PRINT, 8'hFF, 4'd0, 4'd0);   // top byte
      add_row(ascp_pkg::CH_ESC, 0, 1, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      // esc after esc prints
      add_row(ascp_pkg::CH_ESC, 0, 1, 1, ascp_pkg::ACT_PRINT, ascp_pkg::CH_ESC, 4'd0, 4'd0);
      add_row(ascp_pkg::CH_ESC, 0, 1, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      add_row(ascp_pkg::CH_OPEN, 0, 1, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      // empty code: defaults
      add_row(ascp_pkg::CH_END, 0, 1, 1, ascp_pkg::ACT_DEF, 8'h00, 4'd7, 4'd0);
      add_row(ascp_pkg::CH_ESC, 0, 0, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      add_row(ascp_pkg::CH_OPEN, 0, 0, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      add_row(ascp_pkg::CH_ZERO + 8'd3, 0, 0, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      add_row(ascp_pkg::CH_ZERO + 8'd7, 0, 0, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      // 37: white fg
      add_row(ascp_pkg::CH_SEP, 0, 1, 1, ascp_pkg::ACT_FG, 8'h00, 4'd15, 4'd0);
      add_row(ascp_pkg::CH_ZERO + 8'd4, 0, 0, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      add_row(ascp_pkg::CH_ZERO + 8'd1, 0, 0, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      add_row(8'h5A, 0, 0, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);   // stray letter ignored
      // 41: red bg
      add_row(ascp_pkg::CH_SEP, 0, 1, 1, ascp_pkg::ACT_BG, 8'h00, 4'd0, 4'd12);
      add_row(ascp_pkg::CH_ZERO + 8'd9, 0, 0, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      add_row(ascp_pkg::CH_ZERO + 8'd9, 0, 0, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      // saturates at 255
      add_row(ascp_pkg::CH_ZERO + 8'd9, 0, 0, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      // unknown code: nothing
      add_row(ascp_pkg::CH_END, 0, 1, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      add_row(ascp_pkg::CH_ESC, 0, 0, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      // end of string mid-escape
      add_row(ascp_pkg::CH_OPEN, 1, 1, 0, ascp_pkg::ACT_PRINT, 8'h00, 4'd0, 4'd0);
      // idle again: prints
      add_row(ascp_pkg::CH_ZERO + 8'd5, 0, 1, 1, ascp_pkg::ACT_PRINT, 8'h35, 4'd0, 4'd0);
      // last flag on a print
      add_row(ascp_pkg::CH_SEP, 1, 1, 1, ascp_pkg::ACT_PRINT, ascp_pkg::CH_SEP, 4'd0, 4'd0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].pinned,
                   directed_rows[i].fires, directed_rows[i].res);
      drain();

      // random phases, each with its own default colors and idling pattern
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_defaults(4'd15, 4'd15);
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               write_defaults(4'd0, 4'd0);
               sender_idle_pct    = 75;
               receiver_stall_pct = 0;
            end
            2: begin
               write_defaults(4'd0, 4'd15);
               sender_idle_pct    = 0;
               receiver_stall_pct = 75;
            end
            default: begin
               write_defaults(4'($urandom_range(15)), 4'($urandom_range(15)));
               sender_idle_pct    = 10;
               receiver_stall_pct = 10;
            end
         endcase
         stim_count = 0;
         while (stim_count < PHASE_ITEMS) random_burst();
         // full stop until the pipe is empty before touching the registers again
         drain();
      end

      if (pending_results.size() != 0) begin
         $display("%0t: %0d results expected but never seen", $time, pending_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/ascp_pkg.sv
src/ascp_if.sv
src/ansi_sgr_color_parser_unit.sv
src/ascp_checker.sv
verif/ansi_sgr_color_parser_unit_test.sv
